// ===== src/bpe_pkg.sv =====
// Shared types, constants and helpers for the Bezier path position evaluator.
// No dependencies; every other file in src uses it by scoped names.
package bpe_pkg;

    localparam int MAX_SEG_DEF = 16;

    localparam int POS_W  = 24;
    localparam int DUR_W  = 16;
    localparam int TICK_W = 32;
    localparam int T_W    = 17;              // t and u, 0..65536
    localparam int K_W    = 34;              // blend weights, up to 2^32
    localparam int ACC_W  = 58;              // weighted sum, |s| < 2^56
    localparam int RND_W  = ACC_W - 32;      // after the 2^32 scale-down
    localparam int SUM_W  = RND_W + 1;       // plus origin
    localparam int MUL_A_W = K_W + 1;
    localparam int MUL_B_W = POS_W + 1;
    localparam int CNT_W  = 5;
    localparam int DIV_STEPS = T_W;

    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    // request codes
    localparam logic [1:0] REQ_LINE = 2'd0;
    localparam logic [1:0] REQ_QUAD = 2'd1;
    localparam logic [1:0] REQ_EVAL = 2'd2;

    // result codes
    localparam logic [1:0] ST_POS      = 2'd0;
    localparam logic [1:0] ST_APPENDED = 2'd1;
    localparam logic [1:0] ST_REJECT   = 2'd2;
    localparam logic [1:0] ST_PAST_END = 2'd3;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [POS_W-1:0] ctrl_x;
        logic signed [POS_W-1:0] ctrl_y;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
        logic [DUR_W-1:0]        duration_ticks;
        logic [TICK_W-1:0]       tick_count;
        logic signed [POS_W-1:0] origin_x;
        logic signed [POS_W-1:0] origin_y;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } t_rsp;

    typedef struct packed {
        logic                    is_quad;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic signed [POS_W-1:0] ex;
        logic signed [POS_W-1:0] ey;
        logic [TICK_W-1:0]       start;
        logic [DUR_W-1:0]        dur;
    } t_seg;

    typedef struct packed {
        logic       load;
        logic       append_wr;
        logic       set_st;
        logic [1:0] st;
        logic       search_step;
        logic       div_init;
        logic       div_step;
        logic       coef_step;
        logic       mac_step;
        logic       fin;
        logic [2:0] phase;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic is_append;
        logic is_eval;
        logic append_ok;
        logic hit;
        logic at_end;
    } t_sts;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > SUM_W'(8388607))
            r = 24'sh7FFFFF;
        else if (v < -SUM_W'(8388608))
            r = 24'sh800000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

// ===== src/bpe_req_if.sv =====
// Request channel: valid/ready handshake carrying one path request beat.
// Depends on bpe_pkg for the payload type.
interface bpe_req_if;
    logic          valid;
    logic          ready;
    bpe_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/bpe_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one status/position beat.
// Depends on bpe_pkg for the payload type.
interface bpe_rsp_if;
    logic          valid;
    logic          ready;
    bpe_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/bpe_ctl.sv =====
// Sequencer for the evaluator: decode, segment walk, divide, blend, deliver.
// Depends on bpe_pkg for command and status structs.
module bpe_ctl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_free,
    input  bpe_pkg::t_sts   i_sts,
    output bpe_pkg::t_cmd   o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_CHECK  = 8'b00000010,
        S_SEARCH = 8'b00000100,
        S_DIV    = 8'b00001000,
        S_COEF   = 8'b00010000,
        S_MAC    = 8'b00100000,
        S_FIN    = 8'b01000000,
        S_DONE   = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic [bpe_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.phase = r_cnt[2:0];
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.is_append) begin
                    o_cmd.set_st = 1'b1;
                    if (i_sts.append_ok) begin
                        o_cmd.append_wr = 1'b1;
                        o_cmd.st        = bpe_pkg::ST_APPENDED;
                    end else begin
                        o_cmd.st = bpe_pkg::ST_REJECT;
                    end
                    n_state = S_DONE;
                end else if (i_sts.is_eval) begin
                    n_state = S_SEARCH;
                end else begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = bpe_pkg::ST_REJECT;
                    n_state      = S_DONE;
                end
            end
            S_SEARCH: begin
                if (i_sts.at_end) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = bpe_pkg::ST_PAST_END;
                    n_state      = S_DONE;
                end else if (i_sts.hit) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = '0;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == bpe_pkg::CNT_W'(bpe_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_COEF;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_COEF: begin
                o_cmd.coef_step = 1'b1;
                if (r_cnt == bpe_pkg::CNT_W'(2)) begin
                    n_cnt   = '0;
                    n_state = S_MAC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MAC: begin
                o_cmd.mac_step = 1'b1;
                if (r_cnt == bpe_pkg::CNT_W'(6)) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule

// ===== src/bpe_dp.sv =====
// Datapath: segment table, walk index, bit-serial divider, shared multiplier.
// Depends on bpe_pkg; driven by bpe_ctl commands.
module bpe_dp #(
    parameter int MAX_SEGMENTS = bpe_pkg::MAX_SEG_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bpe_pkg::t_cmd i_cmd,
    input  bpe_pkg::t_req i_req,
    output bpe_pkg::t_sts o_sts,
    output bpe_pkg::t_rsp o_rsp
);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int PW = bpe_pkg::POS_W;
    localparam int TW = bpe_pkg::T_W;
    localparam int KW = bpe_pkg::K_W;
    localparam int AC = bpe_pkg::ACC_W;

    bpe_pkg::t_seg mem [MAX_SEGMENTS];
    bpe_pkg::t_seg r_rd, w_seg;
    bpe_pkg::t_req r_req;
    bpe_pkg::t_rsp r_rsp;

    logic [CW-1:0]  r_count, r_idx, n_idx;
    logic [bpe_pkg::TICK_W-1:0] r_total;
    logic signed [PW-1:0] r_prev_x, r_prev_y;
    logic [TW-1:0]  r_rem, r_q, rem_sub, t_val, u_val;
    logic           div_ge;
    logic [KW-1:0]  r_k0, r_k1, r_k2, k_sel;
    logic signed [AC-1:0] r_prod, r_acc_x, r_acc_y, rnd_x, rnd_y;
    logic signed [bpe_pkg::MUL_A_W-1:0] mul_a;
    logic signed [bpe_pkg::MUL_B_W-1:0] mul_b;
    logic signed [bpe_pkg::MUL_A_W+bpe_pkg::MUL_B_W-1:0] mul_p;
    logic signed [PW-1:0] op_sel;
    logic [bpe_pkg::TICK_W:0] end_time;
    logic [bpe_pkg::TICK_W-1:0] elapsed;
    logic signed [bpe_pkg::SUM_W-1:0] sum_x, sum_y;

    // walk index: restart on load, advance one entry per search step
    always_comb begin
        if (i_cmd.load)
            n_idx = '0;
        else if (i_cmd.search_step)
            n_idx = r_idx + 1'b1;
        else
            n_idx = r_idx;
    end

    always_comb begin
        w_seg.is_quad = (r_req.req_type == bpe_pkg::REQ_QUAD);
        w_seg.cx      = w_seg.is_quad ? r_req.ctrl_x : '0;
        w_seg.cy      = w_seg.is_quad ? r_req.ctrl_y : '0;
        w_seg.ex      = r_req.end_x;
        w_seg.ey      = r_req.end_y;
        w_seg.start   = r_total;
        w_seg.dur     = r_req.duration_ticks;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append_wr)
            mem[r_count[AW-1:0]] <= w_seg;
        r_rd <= mem[n_idx[AW-1:0]];
    end

    assign end_time = {1'b0, r_rd.start} + {{(bpe_pkg::TICK_W+1-bpe_pkg::DUR_W){1'b0}}, r_rd.dur};
    assign elapsed  = r_req.tick_count - r_rd.start;

    always_comb begin
        o_sts.is_append = (r_req.req_type == bpe_pkg::REQ_LINE) ||
                          (r_req.req_type == bpe_pkg::REQ_QUAD);
        o_sts.is_eval   = (r_req.req_type == bpe_pkg::REQ_EVAL);
        o_sts.append_ok = (r_req.duration_ticks != '0) && (r_count < CW'(MAX_SEGMENTS));
        o_sts.hit       = (end_time >= {1'b0, r_req.tick_count});
        o_sts.at_end    = (r_idx == r_count);
    end

    // restoring divide, one quotient bit per step
    assign div_ge  = (r_rem >= {1'b0, r_rd.dur});
    assign rem_sub = div_ge ? (r_rem - {1'b0, r_rd.dur}) : r_rem;
    assign t_val   = (r_q > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : r_q;
    assign u_val   = bpe_pkg::T_ONE - t_val;

    // shared multiplier operands
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        k_sel  = r_k0;
        op_sel = r_prev_x;
        unique case (i_cmd.phase)
            3'd0: begin k_sel = r_k0; op_sel = r_prev_x; end
            3'd1: begin k_sel = r_k1; op_sel = r_rd.cx;  end
            3'd2: begin k_sel = r_k2; op_sel = r_rd.ex;  end
            3'd3: begin k_sel = r_k0; op_sel = r_prev_y; end
            3'd4: begin k_sel = r_k1; op_sel = r_rd.cy;  end
            3'd5: begin k_sel = r_k2; op_sel = r_rd.ey;  end
            default: begin k_sel = r_k0; op_sel = r_prev_x; end
        endcase
        if (i_cmd.coef_step) begin
            mul_a = bpe_pkg::MUL_A_W'((i_cmd.phase == 3'd2) ? t_val : u_val);
            mul_b = bpe_pkg::MUL_B_W'((i_cmd.phase == 3'd0) ? u_val : t_val);
        end else begin
            mul_a = {1'b0, k_sel};
            mul_b = bpe_pkg::MUL_B_W'(op_sel);
        end
    end
    assign mul_p = mul_a * mul_b;

    assign rnd_x = r_acc_x + (AC'(1) <<< 31);
    assign rnd_y = r_acc_y + (AC'(1) <<< 31);
    assign sum_x = bpe_pkg::SUM_W'($signed(rnd_x[AC-1:32])) + bpe_pkg::SUM_W'(r_req.origin_x);
    assign sum_y = bpe_pkg::SUM_W'($signed(rnd_y[AC-1:32])) + bpe_pkg::SUM_W'(r_req.origin_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
            r_idx   <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_cmd.append_wr) begin
                r_count <= r_count + 1'b1;
                r_total <= r_total + bpe_pkg::TICK_W'(r_req.duration_ticks);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end
        if (i_cmd.search_step) begin
            r_prev_x <= r_rd.ex;
            r_prev_y <= r_rd.ey;
        end
        if (i_cmd.div_init) begin
            r_rem   <= (r_req.tick_count < r_rd.start) ? '0 : elapsed[TW-1:0];
            r_q     <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= {rem_sub[TW-2:0], 1'b0};
            r_q   <= {r_q[TW-2:0], div_ge};
        end
        if (i_cmd.coef_step) begin
            // lines use weights u and t scaled up by 2^16, no middle term
            unique case (i_cmd.phase)
                3'd0: r_k0 <= r_rd.is_quad ? mul_p[KW-1:0] : {1'b0, u_val, 16'h0};
                3'd1: r_k1 <= r_rd.is_quad ? {mul_p[KW-2:0], 1'b0} : '0;
                default: r_k2 <= r_rd.is_quad ? mul_p[KW-1:0] : {1'b0, t_val, 16'h0};
            endcase
        end
        if (i_cmd.mac_step) begin
            r_prod <= mul_p[AC-1:0];
            if (i_cmd.phase >= 3'd1 && i_cmd.phase <= 3'd3)
                r_acc_x <= r_acc_x + r_prod;
            if (i_cmd.phase >= 3'd4)
                r_acc_y <= r_acc_y + r_prod;
        end
        if (i_cmd.set_st) begin
            r_rsp.status <= i_cmd.st;
            r_rsp.pos_x  <= '0;
            r_rsp.pos_y  <= '0;
        end
        if (i_cmd.fin) begin
            r_rsp.status <= bpe_pkg::ST_POS;
            r_rsp.pos_x  <= bpe_pkg::sat_pos(sum_x);
            r_rsp.pos_y  <= bpe_pkg::sat_pos(sum_y);
        end
    end

    assign o_rsp = r_rsp;
endmodule

// ===== src/bezier_path_position_evaluator_core.sv =====
// Top level of the Bezier path position evaluator: sequencer, datapath, result register.
// Depends on bpe_pkg, bpe_req_if, bpe_rsp_if, bpe_ctl and bpe_dp.
//
//   channel   dir   handshake        beat payload
//   i_req     in    valid / ready    req_type, control, end, duration, tick, origin
//   o_rsp     out   valid / ready    status, pos_x, pos_y
//
// Appends and rejects pass through accept, decode and deliver. An evaluate examines
// n table entries (1 to MAX_SEGMENTS), one table entry per cycle, then runs 17
// divider steps, the weight and multiply-add steps on the single shared multiplier
// and a finish step. A past-end evaluate examines every table entry first. One
// item is in flight at a time; a finished result waits in the output register while
// the next beat is accepted. Reset (i_rst_n low, synchronous) empties the table;
// stalls on o_rsp hold the block.
module bezier_path_position_evaluator_core #(
    parameter int MAX_SEGMENTS = bpe_pkg::MAX_SEG_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    bpe_req_if.sink   i_req,
    bpe_rsp_if.source o_rsp
);
    bpe_pkg::t_cmd cmd;
    bpe_pkg::t_sts sts;
    bpe_pkg::t_rsp dp_rsp;
    bpe_pkg::t_rsp r_out;
    logic          r_out_valid;
    logic          out_free;

    // the output register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || o_rsp.ready;

    bpe_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bpe_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req.data),
        .o_sts   (sts),
        .o_rsp   (dp_rsp)
    );

    // result register: load when the sequencer delivers, drop valid once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load)
            r_out <= dp_rsp;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // one item at a time: no second accept right after the first
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while an item is in flight");

    // positions are zero on every non-position result
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.status != bpe_pkg::ST_POS) |->
        (o_rsp.data.pos_x == '0 && o_rsp.data.pos_y == '0))
        else $error("nonzero position on a status-only result");

    // the table is written only when the append passed its checks
    a_append_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.append_wr |-> sts.append_ok)
        else $error("segment written on a rejected append");

    // the result register never loads over an undelivered beat
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> out_free)
        else $error("result overwritten before delivery");
endmodule

// ===== bench/tb_bezier_path_position_evaluator_core.sv =====
`timescale 1ns / 1ps
// Testbench for bezier_path_position_evaluator_core: directed table, then random paths.
// Depends on bpe_pkg, bpe_req_if, bpe_rsp_if and the core; checks against its own path predictor.
module tb_bezier_path_position_evaluator_core;

    localparam int NSEG = bpe_pkg::MAX_SEG_DEF;
    localparam int N_RANDOM = 1750;
    localparam longint CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    longint cycles;
    int fails;

    bpe_req_if req_ch ();
    bpe_rsp_if rsp_ch ();

    bezier_path_position_evaluator_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // Path table mirror: what the block should hold after each accepted append.
    bpe_pkg::t_seg path_tab [NSEG];
    int     path_len;
    longint path_end;       // sum of appended durations, kept as 32-bit wrap
    bpe_pkg::t_rsp pending_rsp[$];

    // Pinned results from the directed table; random rows carry no pin.
    typedef struct {
        bpe_pkg::t_req req;
        bit            pinned;
        bpe_pkg::t_rsp rsp;
    } t_row;
    t_row rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Round s / 2^k to nearest, ties toward plus infinity (>>> floors).
    function automatic longint round_down(input longint s, input int k);
        return (s + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [bpe_pkg::POS_W-1:0] clamp_pos(input longint v);
        if (v > 8388607) return 24'sh7FFFFF;
        if (v < -8388608) return 24'sh800000;
        return v[bpe_pkg::POS_W-1:0];
    endfunction

    function automatic longint blend(input bit quad, input longint p0, input longint c,
                                     input longint p1, input longint t);
        longint u;
        u = 65536 - t;
        // Split the squared weights so intermediate products stay below 2^63.
        if (quad)
            return round_down((u * u) * p0 + (2 * u * t) * c + (t * t) * p1, 32);
        return round_down(u * p0 + t * p1, 16);
    endfunction

    // Advance the path mirror by one request and return the result it should give.
    function automatic bpe_pkg::t_rsp path_step(input bpe_pkg::t_req r);
        bpe_pkg::t_rsp o;
        int     i;
        longint el, t, sx, sy;
        o = '{status: bpe_pkg::ST_REJECT, pos_x: '0, pos_y: '0};
        if (r.req_type == bpe_pkg::REQ_LINE || r.req_type == bpe_pkg::REQ_QUAD) begin
            if (r.duration_ticks == 0 || path_len >= NSEG) return o;
            path_tab[path_len].is_quad = (r.req_type == bpe_pkg::REQ_QUAD);
            path_tab[path_len].cx = (r.req_type == bpe_pkg::REQ_QUAD) ? r.ctrl_x : '0;
            path_tab[path_len].cy = (r.req_type == bpe_pkg::REQ_QUAD) ? r.ctrl_y : '0;
            path_tab[path_len].ex = r.end_x;
            path_tab[path_len].ey = r.end_y;
            path_tab[path_len].start = path_end[31:0];
            path_tab[path_len].dur = r.duration_ticks;
            path_end = (path_end + r.duration_ticks) & 64'hFFFF_FFFF;
            path_len++;
            o.status = bpe_pkg::ST_APPENDED;
            return o;
        end
        if (r.req_type != bpe_pkg::REQ_EVAL) return o;
        for (i = 0; i < path_len; i++)
            if (longint'(path_tab[i].start) + path_tab[i].dur >= longint'(r.tick_count)) break;
        if (i >= path_len) begin
            o.status = bpe_pkg::ST_PAST_END;
            return o;
        end
        el = (r.tick_count >= path_tab[i].start) ? r.tick_count - path_tab[i].start : 0;
        t = (el << 16) / path_tab[i].dur;
        if (t > 65536) t = 65536;
        sx = (i > 0) ? longint'(path_tab[i-1].ex) : 0;
        sy = (i > 0) ? longint'(path_tab[i-1].ey) : 0;
        o.status = bpe_pkg::ST_POS;
        o.pos_x = clamp_pos(blend(path_tab[i].is_quad, sx, path_tab[i].cx, path_tab[i].ex, t)
                            + longint'(r.origin_x));
        o.pos_y = clamp_pos(blend(path_tab[i].is_quad, sy, path_tab[i].cy, path_tab[i].ey, t)
                            + longint'(r.origin_y));
        return o;
    endfunction

    function automatic bpe_pkg::t_req rand_req(input logic [1:0] kind);
        bpe_pkg::t_req r;
        r.req_type = kind;
        r.ctrl_x = bpe_pkg::POS_W'($urandom); r.ctrl_y = bpe_pkg::POS_W'($urandom);
        r.end_x = bpe_pkg::POS_W'($urandom);  r.end_y = bpe_pkg::POS_W'($urandom);
        // Keep coordinates mostly modest so curves stay in range, sometimes full scale.
        if ($urandom_range(0, 3) != 0) begin
            r.ctrl_x = $signed(r.ctrl_x) >>> 6; r.ctrl_y = $signed(r.ctrl_y) >>> 6;
            r.end_x = $signed(r.end_x) >>> 6;   r.end_y = $signed(r.end_y) >>> 6;
        end
        r.duration_ticks = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                           16'($urandom_range(1, 300));
        if ($urandom_range(0, 40) == 0) r.duration_ticks = '0;
        r.tick_count = $urandom;
        r.origin_x = bpe_pkg::POS_W'($urandom); r.origin_y = bpe_pkg::POS_W'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            r.origin_x = $signed(r.origin_x) >>> 4; r.origin_y = $signed(r.origin_y) >>> 4;
        end
        return r;
    endfunction

    function automatic t_row mk_row(input bpe_pkg::t_req r, input bit pin, input logic [1:0] st,
                                    input logic signed [bpe_pkg::POS_W-1:0] px,
                                    input logic signed [bpe_pkg::POS_W-1:0] py);
        t_row w;
        w.req = r; w.pinned = pin;
        w.rsp = '{status: st, pos_x: px, pos_y: py};
        return w;
    endfunction

    function automatic bpe_pkg::t_req mk_req(input logic [1:0] k, input int cx, input int cy,
                                             input int ex, input int ey, input int d,
                                             input longint tk, input int ox, input int oy);
        bpe_pkg::t_req r;
        r = '{req_type: k,
              ctrl_x: bpe_pkg::POS_W'(cx), ctrl_y: bpe_pkg::POS_W'(cy),
              end_x: bpe_pkg::POS_W'(ex), end_y: bpe_pkg::POS_W'(ey),
              duration_ticks: bpe_pkg::DUR_W'(d), tick_count: bpe_pkg::TICK_W'(tk),
              origin_x: bpe_pkg::POS_W'(ox), origin_y: bpe_pkg::POS_W'(oy)};
        return r;
    endfunction

    task automatic build_directed();
        // Empty table: evaluate is past end.
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0, 0, 0),
                              1, bpe_pkg::ST_PAST_END, 0, 0));
        // Zero duration and an unknown request are rejected.
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_LINE, 5, 5, 100, 100, 0, 0, 0, 0),
                              1, bpe_pkg::ST_REJECT, 0, 0));
        rows.push_back(mk_row(mk_req(2'd3, -1, -1, -1, -1, 65535, 32'hFFFFFFFF, -1, -1),
                              1, bpe_pkg::ST_REJECT, 0, 0));
        // Line to (25600,-25600) over 100 ticks; control point ignored.
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_LINE, 777, 777, 25600, -25600, 100, 0, 0, 0),
                              1, bpe_pkg::ST_APPENDED, 0, 0));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0, 10, 20),
                              1, bpe_pkg::ST_POS, 10, 20));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 50, 0, 0),
                              1, bpe_pkg::ST_POS, 12800, -12800));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 100, 0, 0),
                              1, bpe_pkg::ST_POS, 25600, -25600));
        // Saturation at both rails.
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 100, 8388607, -8388608),
                              1, bpe_pkg::ST_POS, 24'sh7FFFFF, 24'sh800000));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 101, 0, 0),
                              1, bpe_pkg::ST_PAST_END, 0, 0));
        // Quadratic with extreme control, max duration; midpoints checked by predictor.
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_QUAD, 8388607, -8388608, -8388608, 8388607,
                                     65535, 0, 0, 0), 1, bpe_pkg::ST_APPENDED, 0, 0));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 101, 0, 0), 0, 0, 0, 0));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 32868, -3, 3),
                              0, 0, 0, 0));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 65635, 0, 0),
                              0, 0, 0, 0));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_QUAD, 100, -100, 0, 0, 1, 0, 0, 0),
                              0, 0, 0, 0));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 65636, 0, 0),
                              0, 0, 0, 0));
        // Fill the table, then one more append is rejected as full.
        for (int k = 0; k < 13; k++)
            rows.push_back(mk_row(mk_req(bpe_pkg::REQ_LINE, 0, 0, k * 256, -k * 256, 65535,
                                         0, 0, 0), 0, 0, 0, 0));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_QUAD, 1, 1, 1, 1, 5, 0, 0, 0),
                              1, bpe_pkg::ST_REJECT, 0, 0));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0, 0),
                              0, 0, 0, 0));
        rows.push_back(mk_row(mk_req(bpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 500000, 0, 0),
                              0, 0, 0, 0));
    endtask

    // Send one beat with a random lead-in gap; predict at acceptance order.
    // Valid stays high after an accept and drops only when a gap follows or the bench drains.
    task automatic send_beat(input t_row w);
        bpe_pkg::t_rsp p;
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) :
              ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.data  <= w.req;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        p = path_step(w.req);
        if (w.pinned && p !== w.rsp) begin
            $error("directed pin: predictor %p, table %p", p, w.rsp);
            fails++;
        end
        pending_rsp.push_back(w.pinned ? w.rsp : p);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, compare each beat with the oldest expectation.
    initial begin
        bpe_pkg::t_rsp e;
        int hold;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_rsp.size() == 0) begin
                    $error("result beat with nothing expected: %p", rsp_ch.data);
                    fails++;
                end else begin
                    e = pending_rsp.pop_front();
                    if (rsp_ch.data.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, rsp_ch.data.status);
                        fails++;
                    end
                    if (rsp_ch.data.pos_x !== e.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", e.pos_x, rsp_ch.data.pos_x);
                        fails++;
                    end
                    if (rsp_ch.data.pos_y !== e.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", e.pos_y, rsp_ch.data.pos_y);
                        fails++;
                    end
                end
            end
            hold = $urandom_range(0, 99);
            if (hold == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= (cycles % 3000 < 600) ? 1'b1 : (hold >= 30 ? 1'b1 : 1'b0);
            end
        end
    end

    // Cycle watchdog.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb_bezier_path_position_evaluator_core NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int n_sent;
        t_row w;
        fails = 0;
        path_len = 0;
        path_end = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        build_directed();
        foreach (rows[k]) send_beat(rows[k]);

        // Random paths: the table stays as the directed part left it, full, so
        // random appends are all rejected and evaluations land on that path.
        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            logic [1:0] k;
            bpe_pkg::t_req r;
            int pick;
            pick = $urandom_range(0, 99);
            if (path_len < NSEG && pick < 25)
                k = 2'($urandom_range(0, 1));
            else if (pick < 28)
                k = 2'($urandom_range(0, 3));
            else
                k = bpe_pkg::REQ_EVAL;
            r = rand_req(k);
            // Aim most evaluations inside the path, some at segment edges.
            if (k == bpe_pkg::REQ_EVAL && path_end > 0 && $urandom_range(0, 7) != 0) begin
                if ($urandom_range(0, 4) == 0 && path_len > 0) begin
                    int s;
                    s = $urandom_range(0, path_len - 1);
                    r.tick_count = bpe_pkg::TICK_W'(path_tab[s].start +
                                   $urandom_range(0, 2) * path_tab[s].dur / 2);
                end else
                    r.tick_count = bpe_pkg::TICK_W'(longint'($urandom) % (path_end + 2));
            end
            w.req = r; w.pinned = 1'b0; w.rsp = '0;
            send_beat(w);
            n_sent++;
            if (n_sent == 900) drain();
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (fails == 0 && pending_rsp.size() == 0)
            $display("tb_bezier_path_position_evaluator_core OK");
        else
            $display("tb_bezier_path_position_evaluator_core NOT OK");
        $finish;
    end
endmodule

// ===== files.f =====
src/bpe_pkg.sv
src/bpe_req_if.sv
src/bpe_rsp_if.sv
src/bpe_ctl.sv
src/bpe_dp.sv
src/bezier_path_position_evaluator_core.sv
bench/tb_bezier_path_position_evaluator_core.sv
